@@ rtl/lruttl_pkg.sv @@
// package for the lru cache with expiry age
// shared operation codes, register addresses and the back-end state encoding; no dependencies
package lruttl_pkg;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
    localparam logic [0:0] REG_TTL_SECONDS = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MATCH,
        BK_REMOVE,
        BK_EVICT,
        BK_STORE,
        BK_DONE
    } back_state_t;

endpackage

@@ rtl/lruttl_if.sv @@
// valid/ready channel interfaces for requests and responses, each a struct-free set of fields
// no dependencies
interface lruttl_req_if #(
    parameter int KW = 64,
    parameter int VW = 64
);
    logic          valid;
    logic          ready;
    logic [1:0]    mode;
    logic [KW-1:0] key_tag;
    logic [VW-1:0] value_handle;
    logic [31:0]   now_seconds;

    modport source (output valid, mode, key_tag, value_handle, now_seconds, input ready);
    modport sink   (input valid, mode, key_tag, value_handle, now_seconds, output ready);
endinterface

interface lruttl_rsp_if #(
    parameter int VW = 64
);
    logic          valid;
    logic          ready;
    logic          hit;
    logic [VW-1:0] found_value;
    logic [31:0]   hit_count;
    logic [31:0]   miss_count;
    logic [31:0]   eviction_count;
    logic [4:0]    occupancy;

    modport source (output valid, hit, found_value, hit_count, miss_count, eviction_count,
                    occupancy, input ready);
    modport sink   (input valid, hit, found_value, hit_count, miss_count, eviction_count,
                    occupancy, output ready);
endinterface

@@ rtl/lruttl_front.sv @@
// front end: accepts requests, classifies the mode and queues them for the back end
// depends on lruttl_pkg and lruttl_req_if
module lruttl_front #(
    parameter int KW    = 64,
    parameter int VW    = 64,
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    lruttl_req_if.sink          req,
    output logic                q_valid,
    input  logic                q_pop,
    output lruttl_pkg::op_t     q_op,
    output logic [KW-1:0]       q_key,
    output logic [VW-1:0]       q_val,
    output logic [31:0]         q_now
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lruttl_pkg::op_t op_mem [DEPTH];
    logic [KW-1:0]   key_mem [DEPTH];
    logic [VW-1:0]   val_mem [DEPTH];
    logic [31:0]     now_mem [DEPTH];

    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push;
    lruttl_pkg::op_t op_in;

    always_comb
    begin
        case (req.mode)
            lruttl_pkg::MODE_LOOKUP: op_in = lruttl_pkg::OP_LOOKUP;
            lruttl_pkg::MODE_INSERT: op_in = lruttl_pkg::OP_INSERT;
            lruttl_pkg::MODE_CLEAR:  op_in = lruttl_pkg::OP_CLEAR;
            default:                 op_in = lruttl_pkg::OP_NOP;
        endcase
    end

    assign req.ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != '0);
    assign q_op      = op_mem[rd_reg];
    assign q_key     = key_mem[rd_reg];
    assign q_val     = val_mem[rd_reg];
    assign q_now     = now_mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = q_pop ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_reg]  <= op_in;
            key_mem[wr_reg] <= req.key_tag;
            val_mem[wr_reg] <= req.value_handle;
            now_mem[wr_reg] <= req.now_seconds;
        end
    end
endmodule

@@ rtl/lruttl_back.sv @@
// back end: tag match, recency update, eviction, store and response register
// depends on lruttl_pkg and lruttl_rsp_if
module lruttl_back #(
    parameter int N  = 16,
    parameter int KW = 64,
    parameter int VW = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  lruttl_pkg::op_t     q_op,
    input  logic [KW-1:0]       q_key,
    input  logic [VW-1:0]       q_val,
    input  logic [31:0]         q_now,
    input  logic [4:0]          max_entries,
    input  logic [31:0]         ttl_seconds,
    lruttl_rsp_if.source        rsp
);
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    lruttl_pkg::back_state_t state_reg, state_next;

    logic [N-1:0]  valid_reg, valid_next;
    logic [KW-1:0] key_reg  [N];
    logic [VW-1:0] val_reg  [N];
    logic [31:0]   time_reg [N];
    logic [IW-1:0] rank_reg [N];
    logic [IW-1:0] rank_next [N];

    logic [N-1:0]  match_reg;
    logic [31:0]   hits_reg, hits_next, miss_reg, miss_next, evict_reg, evict_next;
    logic          hit_reg, hit_next;
    logic [VW-1:0] found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0] occ_reg, occ_next;

    logic [N-1:0]  match_now, free_first;
    logic          any_match, any_free, expired, do_store;
    logic [IW-1:0] sel_idx, sel_rank, free_idx, old_idx;
    logic [CW-1:0] cap;
    logic [N-1:0]  clr_mask;
    logic          do_shift_dn, do_promote, do_age_all;

    always_comb
    begin
        for (int i = 0; i < N; i++)
            match_now[i] = valid_reg[i] && (key_reg[i] == q_key);
    end

    // one-hot to index, and oldest slot / first free slot
    always_comb
    begin
        sel_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        any_free = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (match_reg[i])
                sel_idx = IW'(i);
            if (valid_reg[i] && rank_reg[i] == IW'(occ_reg - 1'b1))
                old_idx = IW'(i);
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            free_first[i] = 1'b0;
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
                any_free = 1'b1;
            end
        end
        if (any_free)
            free_first[free_idx] = 1'b1;
    end

    assign any_match = |match_reg;
    assign expired   = (q_now - time_reg[sel_idx]) >= ttl_seconds;
    assign cap       = (32'(max_entries) > 32'(N)) ? CW'(N) : CW'(max_entries);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        evict_next     = evict_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        occ_next       = occ_reg;
        q_pop          = 1'b0;
        clr_mask       = '0;
        sel_rank       = rank_reg[sel_idx];
        do_shift_dn    = 1'b0;
        do_promote     = 1'b0;
        do_age_all     = 1'b0;
        do_store       = 1'b0;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            lruttl_pkg::BK_IDLE:
            begin
                // start only once the previous response has left, so its fields stay put
                if (q_valid && (!rsp_valid_reg || rsp.ready))
                    state_next = lruttl_pkg::BK_MATCH;
            end
            lruttl_pkg::BK_MATCH:
            begin
                hit_next   = 1'b0;
                found_next = '0;
                case (q_op)
                    lruttl_pkg::OP_LOOKUP:
                    begin
                        if (!any_match || expired)
                            miss_next = miss_reg + 1'b1;
                        if (any_match && expired)
                        begin
                            clr_mask    = match_reg;
                            do_shift_dn = 1'b1;
                            occ_next    = occ_reg - 1'b1;
                        end
                        else if (any_match)
                        begin
                            do_promote = 1'b1;
                            hits_next  = hits_reg + 1'b1;
                            hit_next   = 1'b1;
                            found_next = val_reg[sel_idx];
                        end
                        state_next = lruttl_pkg::BK_DONE;
                    end
                    lruttl_pkg::OP_INSERT:
                    begin
                        if (any_match)
                        begin
                            clr_mask    = match_reg;
                            do_shift_dn = 1'b1;
                            occ_next    = occ_reg - 1'b1;
                        end
                        state_next = lruttl_pkg::BK_EVICT;
                    end
                    lruttl_pkg::OP_CLEAR:
                    begin
                        valid_next = '0;
                        occ_next   = '0;
                        state_next = lruttl_pkg::BK_DONE;
                    end
                    default:
                        state_next = lruttl_pkg::BK_DONE;
                endcase
            end
            lruttl_pkg::BK_EVICT:
            begin
                // one eviction per cycle, oldest entry has rank occupancy-1
                if (occ_reg != '0 && occ_reg >= cap)
                begin
                    clr_mask   = '0;
                    clr_mask[old_idx] = 1'b1;
                    occ_next   = occ_reg - 1'b1;
                    evict_next = evict_reg + 1'b1;
                end
                else
                    state_next = lruttl_pkg::BK_STORE;
            end
            lruttl_pkg::BK_STORE:
            begin
                if (any_free)
                begin
                    do_age_all = 1'b1;
                    do_store   = 1'b1;
                    occ_next   = occ_reg + 1'b1;
                end
                state_next = lruttl_pkg::BK_DONE;
            end
            lruttl_pkg::BK_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    q_pop          = 1'b1;
                    state_next     = lruttl_pkg::BK_IDLE;
                end
            end
            default:
                state_next = lruttl_pkg::BK_IDLE;
        endcase

        valid_next = valid_next & ~clr_mask;
        if (do_store)
            valid_next = valid_next | free_first;

        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_shift_dn && valid_reg[i] && rank_reg[i] > sel_rank)
                rank_next[i] = rank_reg[i] - 1'b1;
            if (state_reg == lruttl_pkg::BK_EVICT && clr_mask != '0 && valid_reg[i]
                && rank_reg[i] > rank_reg[old_idx])
                rank_next[i] = rank_reg[i] - 1'b1;
            if (do_promote && valid_reg[i] && rank_reg[i] < sel_rank)
                rank_next[i] = rank_reg[i] + 1'b1;
            if (do_promote && match_reg[i])
                rank_next[i] = '0;
            if (do_age_all && valid_reg[i])
                rank_next[i] = rank_reg[i] + 1'b1;
            if (do_store && free_first[i])
                rank_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lruttl_pkg::BK_IDLE;
            valid_reg     <= '0;
            match_reg     <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            evict_reg     <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            match_reg     <= match_now;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            evict_reg     <= evict_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
            occ_reg       <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            rank_reg[i] <= rank_next[i];
            if (do_store && free_first[i])
            begin
                key_reg[i]  <= q_key;
                val_reg[i]  <= q_val;
                time_reg[i] <= q_now;
            end
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = hit_reg;
    assign rsp.found_value    = found_reg;
    assign rsp.hit_count      = hits_reg;
    assign rsp.miss_count     = miss_reg;
    assign rsp.eviction_count = evict_reg;
    assign rsp.occupancy      = 5'(occ_reg);
endmodule

@@ rtl/lru_cache_with_ttl.sv @@
// top level of the lru cache with expiry age: config registers, front and back ends
// depends on lruttl_pkg, lruttl_if, lruttl_front, lruttl_back
//
// usage: requests arrive on req (mode, key_tag, value_handle, now_seconds), one
// response per request leaves on rsp, in order. mode 0 looks up, 1 inserts or
// replaces, 2 clears the table, 3 does nothing. the apb port writes max_entries
// (address 0) and ttl_seconds (address 4); write them only while idle.
// a request queue of two entries sits between the front end and the back end.
// the back end matches all tags in parallel into a registered match vector, then:
//   lookup, clear and no-op pass through the match and done states
//   insert passes through match, evict (one eviction per cycle while occupancy is
//   at or over the max_entries cap), store and done
// the response register lets the front end keep queuing while the receiver
// stalls; the back end starts the next transaction only after a pending response
// is taken. reset empties the table, clears counters and the queue, and sets
// max_entries to 16 and ttl_seconds to 60.
module lru_cache_with_ttl #(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lruttl_req_if.sink  req,
    lruttl_rsp_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [4:0]  max_entries_reg;
    logic [31:0] ttl_reg;
    logic        q_valid, q_pop;
    lruttl_pkg::op_t q_op;
    logic [KEY_WIDTH-1:0]   q_key;
    logic [VALUE_WIDTH-1:0] q_val;
    logic [31:0] q_now;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lruttl_pkg::REG_TTL_SECONDS) ? ttl_reg
                  : (paddr[2] == lruttl_pkg::REG_MAX_ENTRIES) ? {27'd0, max_entries_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= 5'd16;
            ttl_reg         <= 32'd60;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == lruttl_pkg::REG_MAX_ENTRIES)
                max_entries_reg <= pwdata[4:0];
            else
                ttl_reg <= pwdata;
        end
    end

    lruttl_front #(.KW(KEY_WIDTH), .VW(VALUE_WIDTH), .DEPTH(2)) u_front (
        .clk, .rst_n, .req,
        .q_valid, .q_pop, .q_op, .q_key, .q_val, .q_now
    );

    lruttl_back #(.N(ENTRIES), .KW(KEY_WIDTH), .VW(VALUE_WIDTH)) u_back (
        .clk, .rst_n,
        .q_valid, .q_pop, .q_op, .q_key, .q_val, .q_now,
        .max_entries(max_entries_reg), .ttl_seconds(ttl_reg), .rsp
    );
endmodule

@@ rtl/lruttl_checker.sv @@
// port-level checker for the lru cache, bound to the top level
// depends on the top level's ports only
module lruttl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_hit,
    input logic [63:0] rsp_found,
    input logic [31:0] rsp_hits,
    input logic [4:0]  rsp_occ
);
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_found)
        && $stable(rsp_hits) && $stable(rsp_occ))
        else $error("response changed while stalled");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_found == 64'd0)
        else $error("found value nonzero on a miss");
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_occ <= 5'd16)
        else $error("occupancy out of range");
    a_hit_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_occ != 5'd0 && rsp_hits != 32'd0)
        else $error("hit reported with empty table");
endmodule

bind lru_cache_with_ttl lruttl_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
    .rsp_found(rsp.found_value), .rsp_hits(rsp.hit_count), .rsp_occ(rsp.occupancy)
);
